FILE: sv/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`default_nettype none

package rau_pkg;

	localparam int RES_NUM_W = 34;
	localparam int RES_DEN_W = 33;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	typedef enum logic [1:0] {
		MSEL_P1,
		MSEL_P2,
		MSEL_PD
	} msel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_SIGN,
		ST_GCD,
		ST_DIVN,
		ST_DIVD
	} state_t;

	typedef struct packed {
		logic  load;
		msel_t msel;
		logic  cap_n1;
		logic  cap_n2;
		logic  cap_d;
		logic  gcd_step;
		logic  div_init_n;
		logic  div_init_d;
		logic  div_step;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic special;
		logic gcd_done;
		logic div_done;
	} sts_t;

endpackage

`default_nettype wire

FILE: sv/rau_ctrl.sv
// Sequencer for the rational arithmetic unit plus the output word handshake.
`default_nettype none

module rau_ctrl import rau_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;
	logic   finish;

	// output register can take a new word when empty or being drained
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// a word finishes after the last division, or in the sign state for 0/1 results
	always_comb begin
		finish = 1'b0;
		case (state_q)
			ST_SIGN: finish = sts.special;
			ST_DIVD: finish = sts.div_done;
			default: finish = 1'b0;
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_MUL1;
			ST_MUL1: state_nx = ST_MUL2;
			ST_MUL2: state_nx = ST_MUL3;
			ST_MUL3: state_nx = ST_SIGN;
			ST_SIGN: begin
				if (!sts.special) state_nx = ST_GCD;
				else if (out_free) state_nx = ST_IDLE;
			end
			ST_GCD: if (sts.gcd_done) state_nx = ST_DIVN;
			ST_DIVN: if (sts.div_done) state_nx = ST_DIVD;
			ST_DIVD: if (sts.div_done && out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.msel = MSEL_P1;
		case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_MUL1: cmd.msel = MSEL_P1;
			ST_MUL2: begin
				cmd.msel   = MSEL_P2;
				cmd.cap_n1 = 1'b1;
			end
			ST_MUL3: begin
				cmd.msel   = MSEL_PD;
				cmd.cap_n2 = 1'b1;
			end
			ST_SIGN: cmd.cap_d = 1'b1;
			ST_GCD: begin
				cmd.gcd_step   = !sts.gcd_done;
				cmd.div_init_n = sts.gcd_done;
			end
			ST_DIVN: begin
				cmd.div_step   = !sts.div_done;
				cmd.div_init_d = sts.div_done;
			end
			ST_DIVD: cmd.div_step = !sts.div_done;
			default: cmd.load = 1'b0;
		endcase
		cmd.out_load = finish && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: sv/rau_dp.sv
// Datapath: operand registers, shared multiplier, binary GCD, restoring divider, output word.
`default_nettype none

module rau_dp import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire cmd_t                          cmd,
	output sts_t                               sts,
	input  wire logic [1:0]                    kind,
	input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
	input  wire logic [OPERAND_WIDTH-2:0]      a_den,
	input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
	input  wire logic [OPERAND_WIDTH-2:0]      b_den,
	output logic signed [RES_NUM_W-1:0]        res_num,
	output logic [RES_DEN_W-1:0]               res_den,
	output logic                               status
);

	localparam int W  = OPERAND_WIDTH;
	localparam int NW = 2 * W;
	localparam int MW = 2 * W - 1;
	localparam int PW = 2 * W + 2;
	localparam int KW = $clog2(MW);
	localparam int CW = $clog2(MW + 1);
	localparam int XW = (MW + 1 > RES_NUM_W) ? MW + 1 : RES_NUM_W;

	logic [1:0]          kind_q;
	logic [W-1:0]        an_q;
	logic [W-1:0]        bn_q;
	logic [W-2:0]        ad_q;
	logic [W-2:0]        bd_q;
	logic signed [W:0]   ma;
	logic signed [W:0]   mb;
	logic signed [PW-1:0] prod_q;
	logic [NW-1:0]       prod_n;
	logic [NW-1:0]       n_q;
	logic [NW-1:0]       n_abs;
	logic [NW-1:0]       d_abs;
	logic                div_zero;
	logic                neg_q;
	logic [MW-1:0]       nmag_q;
	logic [MW-1:0]       dmag_q;
	logic [MW-1:0]       u_q;
	logic [MW-1:0]       v_q;
	logic [KW-1:0]       k_q;
	logic [MW-1:0]       u_nx;
	logic [MW-1:0]       v_nx;
	logic [KW-1:0]       k_nx;
	logic [MW-1:0]       g_q;
	logic [MW-1:0]       rem_q;
	logic [MW-1:0]       quo_q;
	logic [CW-1:0]       cnt_q;
	logic [MW:0]         trial;
	logic                ge;
	logic [MW:0]         diff;
	logic [MW-1:0]       nres_q;
	logic [XW-1:0]       num_ext;
	logic [XW-1:0]       num_sgn;
	logic [XW-1:0]       den_ext;
	logic signed [RES_NUM_W-1:0] res_num_q;
	logic [RES_DEN_W-1:0] res_den_q;
	logic                status_q;

	assign div_zero = (kind_q == KIND_DIV) && (bn_q == '0);

	// shared signed multiplier, denominators zero-extended
	always_comb begin
		ma = {an_q[W-1], an_q};
		mb = {2'b00, bd_q};
		case (cmd.msel)
			MSEL_P1: begin
				ma = {an_q[W-1], an_q};
				mb = (kind_q == KIND_MUL) ? {bn_q[W-1], bn_q} : {2'b00, bd_q};
			end
			MSEL_P2: begin
				ma = {bn_q[W-1], bn_q};
				mb = {2'b00, ad_q};
			end
			MSEL_PD: begin
				ma = {2'b00, ad_q};
				mb = (kind_q == KIND_DIV) ? {bn_q[W-1], bn_q} : {2'b00, bd_q};
			end
			default: begin
				ma = {an_q[W-1], an_q};
				mb = {2'b00, bd_q};
			end
		endcase
	end

	assign prod_n = prod_q[NW-1:0];
	assign n_abs  = n_q[NW-1] ? (NW'(0) - n_q) : n_q;
	assign d_abs  = prod_n[NW-1] ? (NW'(0) - prod_n) : prod_n;

	// one binary GCD step: halve evens, else halve the difference of odds
	always_comb begin
		u_nx = u_q;
		v_nx = v_q;
		k_nx = k_q;
		if (!u_q[0] && !v_q[0]) begin
			u_nx = u_q >> 1;
			v_nx = v_q >> 1;
			k_nx = k_q + KW'(1);
		end else if (!u_q[0]) begin
			u_nx = u_q >> 1;
		end else if (!v_q[0]) begin
			v_nx = v_q >> 1;
		end else if (u_q >= v_q) begin
			u_nx = (u_q - v_q) >> 1;
		end else begin
			v_nx = (v_q - u_q) >> 1;
		end
	end

	// restoring divider step
	assign trial = {rem_q, quo_q[MW-1]};
	assign ge    = (trial >= {1'b0, g_q});
	assign diff  = trial - {1'b0, g_q};

	assign sts.special  = (n_q == '0) || div_zero;
	assign sts.gcd_done = (u_q == '0);
	assign sts.div_done = (cnt_q == CW'(MW));

	assign num_ext = XW'(nres_q);
	assign num_sgn = neg_q ? (XW'(0) - num_ext) : num_ext;
	assign den_ext = XW'(quo_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			an_q   <= a_num;
			bn_q   <= b_num;
			ad_q   <= (a_den == '0) ? (W-1)'(1) : a_den;
			bd_q   <= (b_den == '0) ? (W-1)'(1) : b_den;
		end
		prod_q <= ma * mb;
		if (cmd.cap_n1) n_q <= prod_n;
		if (cmd.cap_n2) begin
			case (kind_q)
				KIND_ADD: n_q <= n_q + prod_n;
				KIND_SUB: n_q <= n_q - prod_n;
				default:  n_q <= n_q;
			endcase
		end
		if (cmd.cap_d) begin
			neg_q  <= n_q[NW-1] ^ prod_n[NW-1];
			nmag_q <= n_abs[MW-1:0];
			dmag_q <= d_abs[MW-1:0];
			u_q    <= n_abs[MW-1:0];
			v_q    <= d_abs[MW-1:0];
			k_q    <= '0;
		end
		if (cmd.gcd_step) begin
			u_q <= u_nx;
			v_q <= v_nx;
			k_q <= k_nx;
		end
		if (cmd.div_init_n) begin
			g_q   <= v_q << k_q;
			quo_q <= nmag_q;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_init_d) begin
			nres_q <= quo_q;
			quo_q  <= dmag_q;
			rem_q  <= '0;
			cnt_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[MW-1:0] : trial[MW-1:0];
			quo_q <= {quo_q[MW-2:0], ge};
			cnt_q <= cnt_q + CW'(1);
		end
		// special flags stay valid from sign through the end of the word
		if (cmd.out_load) begin
			if (sts.special) begin
				res_num_q <= '0;
				res_den_q <= RES_DEN_W'(1);
				status_q  <= div_zero;
			end else begin
				res_num_q <= $signed(num_sgn[RES_NUM_W-1:0]);
				res_den_q <= den_ext[RES_DEN_W-1:0];
				status_q  <= 1'b0;
			end
		end
	end

	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign status  = status_q;

endmodule

`default_nettype wire

FILE: sv/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit: fraction add/sub/mul/div reduced to lowest terms.
// Timing: 0/1 results finish at the sign step; otherwise the time is set by the one-step-per-cycle
//   binary GCD loop and the two bit-serial divisions by the GCD.
// Handshake: one word in flight, so a new word is taken only once the last one is in the output
//   register; a new word is taken while the last result waits.
// Reset: arst_n clears the sequencer and output valid; data registers are not reset.
`default_nettype none

module rational_arithmetic_unit_core import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      kind,
	input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
	input  wire logic [OPERAND_WIDTH-2:0]        a_den,
	input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
	input  wire logic [OPERAND_WIDTH-2:0]        b_den,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [RES_NUM_W-1:0]          res_num,
	output logic [RES_DEN_W-1:0]                 res_den,
	output logic                                 status
);

	// Controller to datapath: one command word per cycle.
	cmd_t cmd;
	// Datapath to controller: zero-result flag and loop exits.
	sts_t sts;

	// Sequence per word:
	//   the multiplier states MUL1, MUL2 and MUL3 form the cross products (n and d),
	//   the sign state takes magnitudes and sign, or shortcuts to 0/1,
	//   binary GCD runs until u reaches zero (g = v << k),
	//   then n/g and d/g each take 2*OPERAND_WIDTH-1 restoring steps.
	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Output register lives in the datapath; it holds a valid word while out_stall is high.
	rau_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.sts     (sts),
		.kind    (kind),
		.a_num   (a_num),
		.a_den   (a_den),
		.b_num   (b_num),
		.b_den   (b_den),
		.res_num (res_num),
		.res_den (res_den),
		.status  (status)
	);

endmodule

`default_nettype wire
